### hw/rtl/kpe_pkg.sv
package kpe_pkg;

  localparam int MAX_WORDS = 32;
  localparam int MAX_PICK  = 16;
  localparam int RANK_W    = 48;
  localparam int DIG_W     = $clog2(MAX_WORDS);
  localparam int NCNT_W    = $clog2(MAX_WORDS + 1);
  localparam int PIDX_W    = $clog2(MAX_PICK);
  localparam int KCNT_W    = $clog2(MAX_PICK + 1);
  localparam int BIT_W     = $clog2(RANK_W);

  localparam logic [3:0] REG_WORD_TOTAL = 4'd0;
  localparam logic [3:0] REG_PICK_COUNT = 4'd1;
  localparam logic [3:0] REG_START_RANK = 4'd2;
  localparam logic [3:0] REG_RUN_LENGTH = 4'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_DIVLAST,
    OP_ROW,
    OP_CMP,
    OP_WSHIFT,
    OP_PREP,
    OP_OUT,
    OP_ADV
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PIDX_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [KCNT_W-1:0] k;
  } sts_t;

endpackage

### hw/rtl/kpe_dp.sv
module kpe_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [3:0]                cfg_index,
  input  logic [47:0]               cfg_data,
  input  kpe_pkg::cmd_t             cmd,
  output kpe_pkg::sts_t             sts,
  output logic [3:0]                out_position,
  output logic [4:0]                out_word_index,
  output logic                      out_last,
  output logic                      out_wrapped,
  output logic                      out_run_done
);

  localparam int DW = kpe_pkg::DIG_W;
  localparam int NW = kpe_pkg::NCNT_W;
  localparam int KW = kpe_pkg::KCNT_W;
  localparam int PW = kpe_pkg::PIDX_W;
  localparam int RW = kpe_pkg::RANK_W;
  localparam int MP = kpe_pkg::MAX_PICK;

  logic [5:0]    word_total_r;
  logic [4:0]    pick_count_r;
  logic [RW-1:0] start_rank_r;
  logic [RW-1:0] run_length_r;

  logic [DW-1:0] digits_r [MP];
  logic [PW-1:0] shifts_r [MP];
  logic [RW-1:0] count_r;
  logic [RW-1:0] rank_r;
  logic [NW-1:0] base_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] di_r;
  logic [PW-1:0] s_r;
  logic          done_r;
  logic          wrap_r;
  logic [3:0]    pos_r;
  logic [4:0]    widx_r;
  logic          last_r;

  logic [NW-1:0] n_eff;
  logic [KW-1:0] k_eff;
  logic [DW-1:0] rd_digit;
  logic [NW:0]   rem_sh;
  logic          rem_ge;
  logic [NW:0]   rem_new;
  logic [DW:0]   cmp_rhs;
  logic [RW-1:0] count_inc;
  logic [MP-1:0] sat;
  logic [MP:0]   carry;

  // Effective n and k after clamping.
  always_comb begin
    if (word_total_r == 6'd0) begin
      n_eff = NW'(1);
    end else if (NW'(word_total_r) > NW'(kpe_pkg::MAX_WORDS) ||
                 word_total_r > 6'(kpe_pkg::MAX_WORDS)) begin
      n_eff = NW'(kpe_pkg::MAX_WORDS);
    end else begin
      n_eff = NW'(word_total_r);
    end
    if (pick_count_r == 5'd0) begin
      k_eff = KW'(1);
    end else if (pick_count_r > 5'(MP)) begin
      k_eff = KW'(MP);
    end else begin
      k_eff = KW'(pick_count_r);
    end
    if (NW'(k_eff) > n_eff) begin
      k_eff = KW'(n_eff);
    end
  end

  assign sts.k = k_eff;

  assign rd_digit = digits_r[cmd.addr];

  // One step of restoring division of the rank by the current base.
  assign rem_sh  = {rem_r, rank_r[RW-1]};
  assign rem_ge  = rem_sh >= {1'b0, base_r};
  assign rem_new = rem_ge ? (rem_sh - {1'b0, base_r}) : rem_sh;

  assign cmp_rhs   = {1'b0, di_r} + (DW+1)'(s_r);
  assign count_inc = (count_r == {RW{1'b1}}) ? count_r : count_r + RW'(1);

  // A digit is saturated when it sits at or above its largest value n-k+i.
  always_comb begin
    carry[0] = 1'b1;
    for (int i = 0; i < MP; i++) begin
      sat[i] = (KW'(i) < k_eff) &&
               (NW'(digits_r[i]) >= (n_eff - NW'(k_eff) + NW'(i)));
      carry[i+1] = carry[i] & sat[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_total_r <= 6'd1;
      pick_count_r <= 5'd1;
      start_rank_r <= '0;
      run_length_r <= '0;
      count_r      <= '0;
      for (int i = 0; i < MP; i++) begin
        digits_r[i] <= '0;
        shifts_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kpe_pkg::REG_WORD_TOTAL: word_total_r <= cfg_data[5:0];
          kpe_pkg::REG_PICK_COUNT: pick_count_r <= cfg_data[4:0];
          kpe_pkg::REG_START_RANK: start_rank_r <= cfg_data;
          kpe_pkg::REG_RUN_LENGTH: run_length_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        kpe_pkg::OP_LOAD:    count_r <= '0;
        kpe_pkg::OP_DIVLAST: digits_r[cmd.addr] <= rem_new[DW-1:0];
        kpe_pkg::OP_WSHIFT:  shifts_r[cmd.addr] <= s_r;
        kpe_pkg::OP_PREP:    count_r <= count_inc;
        kpe_pkg::OP_ADV: begin
          for (int i = 0; i < MP; i++) begin
            if (KW'(i) < k_eff && carry[i]) begin
              digits_r[i] <= sat[i] ? '0 : digits_r[i] + DW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      kpe_pkg::OP_LOAD: begin
        rank_r <= start_rank_r;
        base_r <= n_eff - NW'(k_eff) + NW'(1);
        rem_r  <= '0;
      end
      kpe_pkg::OP_DIV: begin
        rank_r <= {rank_r[RW-2:0], rem_ge};
        rem_r  <= rem_new[NW-1:0];
      end
      kpe_pkg::OP_DIVLAST: begin
        rank_r <= {rank_r[RW-2:0], rem_ge};
        rem_r  <= '0;
        base_r <= base_r + NW'(1);
      end
      kpe_pkg::OP_ROW: begin
        di_r <= rd_digit;
        s_r  <= '0;
      end
      kpe_pkg::OP_CMP: begin
        if ({1'b0, rd_digit} <= cmp_rhs) begin
          s_r <= s_r + PW'(1);
        end
      end
      kpe_pkg::OP_PREP: begin
        done_r <= count_inc >= run_length_r;
        wrap_r <= carry[k_eff];
      end
      kpe_pkg::OP_OUT: begin
        pos_r  <= 4'(cmd.addr);
        widx_r <= 5'(rd_digit + DW'(shifts_r[cmd.addr]));
        last_r <= (KW'(cmd.addr) + KW'(1)) == k_eff;
      end
      default: ;
    endcase
  end

  assign out_position   = pos_r;
  assign out_word_index = widx_r;
  assign out_last       = last_r;
  assign out_wrapped    = wrap_r;
  assign out_run_done   = done_r;

endmodule

### hw/rtl/kpe_ctrl.sv
module kpe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  kpe_pkg::sts_t sts,
  output kpe_pkg::cmd_t cmd
);

  localparam int KW = kpe_pkg::KCNT_W;
  localparam int PW = kpe_pkg::PIDX_W;
  localparam int BW = kpe_pkg::BIT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ROW, S_CMP, S_PREP, S_EMIT, S_ADV
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] i_r, i_nxt;
  logic [KW-1:0] j_r, j_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          after_adv_r, after_adv_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          i_last;

  assign i_last = (KW'(i_r) + KW'(1)) == sts.k;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    bit_nxt       = bit_r;
    pos_nxt       = pos_r;
    after_adv_nxt = after_adv_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op        = kpe_pkg::OP_NONE;
    cmd.addr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            cmd.op    = kpe_pkg::OP_LOAD;
            i_nxt     = '0;
            bit_nxt   = '0;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_DIV: begin
        cmd.addr = i_r;
        if (bit_r == BW'(kpe_pkg::RANK_W - 1)) begin
          cmd.op  = kpe_pkg::OP_DIVLAST;
          bit_nxt = '0;
          if (i_last) begin
            i_nxt         = '0;
            after_adv_nxt = 1'b0;
            state_nxt     = S_ROW;
          end else begin
            i_nxt = i_r + PW'(1);
          end
        end else begin
          cmd.op  = kpe_pkg::OP_DIV;
          bit_nxt = bit_r + BW'(1);
        end
      end
      S_ROW: begin
        cmd.op    = kpe_pkg::OP_ROW;
        cmd.addr  = i_r;
        j_nxt     = KW'(i_r) + KW'(1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (j_r < sts.k) begin
          cmd.op   = kpe_pkg::OP_CMP;
          cmd.addr = j_r[PW-1:0];
          j_nxt    = j_r + KW'(1);
        end else begin
          cmd.op   = kpe_pkg::OP_WSHIFT;
          cmd.addr = i_r;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = after_adv_r ? S_IDLE : S_PREP;
          end else begin
            i_nxt     = i_r + PW'(1);
            state_nxt = S_ROW;
          end
        end
      end
      S_PREP: begin
        // The wrap and run flags are shared with a word that may still be held.
        if (!out_valid_r || out_ready) begin
          cmd.op    = kpe_pkg::OP_PREP;
          pos_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.addr = pos_r;
        if (!out_valid_r || out_ready) begin
          cmd.op        = kpe_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          if ((KW'(pos_r) + KW'(1)) == sts.k) begin
            state_nxt = S_ADV;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      S_ADV: begin
        cmd.op        = kpe_pkg::OP_ADV;
        i_nxt         = '0;
        after_adv_nxt = 1'b1;
        state_nxt     = S_ROW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      bit_r       <= '0;
      pos_r       <= '0;
      after_adv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      bit_r       <= bit_nxt;
      pos_r       <= pos_nxt;
      after_adv_r <= after_adv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word sequence was starting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> (KW'(pos_r) < sts.k))
    else $error("emit position beyond pick count");

endmodule

### hw/rtl/k_permutation_enumerator.sv
// k-permutation enumerator: steps through ordered selections of k distinct
// word indices out of n.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write register
// cfg_index (0 word_total, 1 pick_count, 2 start_rank, 3 run_length);
// cfg_ready is always high. Write only while the block is idle.
// Input: one word per request; in_tdata[0] is restart.
// Output: k words per request, one per position, tlast on the final one.
// A restart first unranks the start rank (one bit of the 48-bit rank
// division per cycle, per digit) and then updates the shifts. Every
// request then passes through an accept step, a prepare step, one output
// word per cycle while the receiver does not stall, an advance step and
// an update of the shifts again. The sequencer handles one request at a
// time; in_tready is high only when it is idle.
// When the receiver stalls, the held output word stays put and the
// sequencer waits. The last output word may still be waiting while the next
// request is accepted; that request's emission waits until it is taken.
// Reset (rst_n low, synchronous) clears digits, shifts, the run counter and
// the configuration registers to their defaults; there is no clearing pass.
module k_permutation_enumerator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] position, [8:4] word_index,
                                  // [9] wrapped, [10] run_done
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  kpe_pkg::cmd_t cmd;
  kpe_pkg::sts_t sts;
  logic [3:0]    position;
  logic [4:0]    word_index;
  logic          wrapped;
  logic          run_done;

  assign cfg_ready = 1'b1;

  kpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kpe_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_position   (position),
    .out_word_index (word_index),
    .out_last       (out_tlast),
    .out_wrapped    (wrapped),
    .out_run_done   (run_done)
  );

  assign out_tdata = {5'd0, run_done, wrapped, word_index, position};

endmodule
